[design/dhl_pkg.sv]
package dhl_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int LENGTH_BITS    = 32;
  localparam int TRIG_FRAC_BITS = 14;

  // CORDIC datapath
  localparam int CORDIC_FRAC  = 40;
  localparam int CORDIC_ITERS = 32;
  localparam int XW           = CORDIC_FRAC + 4;
  localparam int ZW           = 34;
  localparam int TURN_SH      = 32 - ANGLE_BITS;
  localparam int RND_SH       = CORDIC_FRAC - TRIG_FRAC_BITS;

  // Trig entry width: signed Q1.TF
  localparam int TW = TRIG_FRAC_BITS + 2;

  // Pipeline depth: prep, iterations, round/unfold, products, round/saturate
  localparam int CORD_LAT = CORDIC_ITERS + 2;
  localparam int NSTAGE   = CORD_LAT + 2;

  // Stream widths, padded to whole bytes
  localparam int IN_RAW  = 2 * LENGTH_BITS + 2 * ANGLE_BITS;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = 8 * TW + 3 * LENGTH_BITS;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  typedef struct packed {
    logic signed [LENGTH_BITS-1:0] trans_z;
    logic signed [LENGTH_BITS-1:0] trans_y;
    logic signed [LENGTH_BITS-1:0] trans_x;
    logic signed [TW-1:0]          rot_22;
    logic signed [TW-1:0]          rot_21;
    logic signed [TW-1:0]          rot_12;
    logic signed [TW-1:0]          rot_11;
    logic signed [TW-1:0]          rot_10;
    logic signed [TW-1:0]          rot_02;
    logic signed [TW-1:0]          rot_01;
    logic signed [TW-1:0]          rot_00;
  } result_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(536870912);
      1:  v = ZW'(316933406);
      2:  v = ZW'(167458907);
      3:  v = ZW'(85004756);
      4:  v = ZW'(42667331);
      5:  v = ZW'(21354465);
      6:  v = ZW'(10679838);
      7:  v = ZW'(5340245);
      8:  v = ZW'(2670163);
      9:  v = ZW'(1335087);
      10: v = ZW'(667544);
      11: v = ZW'(333772);
      12: v = ZW'(166886);
      13: v = ZW'(83443);
      14: v = ZW'(41722);
      15: v = ZW'(20861);
      16: v = ZW'(10430);
      17: v = ZW'(5215);
      18: v = ZW'(2608);
      19: v = ZW'(1304);
      20: v = ZW'(652);
      21: v = ZW'(326);
      22: v = ZW'(163);
      23: v = ZW'(81);
      24: v = ZW'(41);
      25: v = ZW'(20);
      26: v = ZW'(10);
      27: v = ZW'(5);
      28: v = ZW'(3);
      29: v = ZW'(1);
      30: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/dhl_cordic.sv]
module dhl_cordic (
  input  logic                                      clk_i,
  input  logic                                      adv_i,
  input  logic        [dhl_pkg::ANGLE_BITS-1:0]     angle_i,
  output logic signed [dhl_pkg::TW-1:0]             cos_o,
  output logic signed [dhl_pkg::TW-1:0]             sin_o
);

  localparam int XW = dhl_pkg::XW;
  localparam int ZW = dhl_pkg::ZW;
  localparam int TW = dhl_pkg::TW;
  localparam int NI = dhl_pkg::CORDIC_ITERS;
  localparam logic signed [XW-1:0] GAIN = 44'sd667681663049;
  localparam logic signed [XW-1:0] RND  = XW'(1) <<< (dhl_pkg::RND_SH - 1);
  localparam logic signed [XW-1:0] LIM  = XW'(1) <<< dhl_pkg::TRIG_FRAC_BITS;

  logic signed [XW-1:0] x_q [NI+1];
  logic signed [XW-1:0] y_q [NI+1];
  logic signed [ZW-1:0] z_q [NI+1];
  logic        [1:0]    quad_q [NI+1];

  logic [31:0]          turn, u;
  logic signed [ZW-1:0] z0;

  // Fold the angle into an octant-centered quadrant
  assign turn = 32'(angle_i) << dhl_pkg::TURN_SH;
  assign u    = turn + 32'h2000_0000;
  assign z0   = $signed(ZW'(u[29:0])) - $signed(ZW'(32'h2000_0000));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z0;
      quad_q[0] <= u[31:30];
    end
  end

  for (genvar k = 0; k < NI; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quad_q[k+1] <= quad_q[k];
        if (z_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - dhl_pkg::atan_turn(k);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + dhl_pkg::atan_turn(k);
        end
      end
    end
  end

  // Round half up, clamp to +-1.0, then unfold the quadrant
  logic signed [XW-1:0] xs, ys, xr, yr;
  logic signed [TW-1:0] c, s, cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    xs = x_q[NI] + RND;
    ys = y_q[NI] + RND;
    xr = xs >>> dhl_pkg::RND_SH;
    yr = ys >>> dhl_pkg::RND_SH;
    if (xr > LIM)       c = TW'(LIM);
    else if (xr < -LIM) c = TW'(-LIM);
    else                c = TW'(xr);
    if (yr > LIM)       s = TW'(LIM);
    else if (yr < -LIM) s = TW'(-LIM);
    else                s = TW'(yr);
    unique case (quad_q[NI])
      2'd0: begin cos_d = c;  sin_d = s;  end
      2'd1: begin cos_d = -s; sin_d = c;  end
      2'd2: begin cos_d = -c; sin_d = -s; end
      2'd3: begin cos_d = s;  sin_d = -c; end
      default: begin cos_d = c; sin_d = s; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[design/dhl_mult.sv]
module dhl_mult (
  input  logic                                   clk_i,
  input  logic                                   adv_i,
  input  logic signed [dhl_pkg::TW-1:0]          ct_i,
  input  logic signed [dhl_pkg::TW-1:0]          st_i,
  input  logic signed [dhl_pkg::TW-1:0]          ca_i,
  input  logic signed [dhl_pkg::TW-1:0]          sa_i,
  input  logic signed [dhl_pkg::LENGTH_BITS-1:0] len_i,
  input  logic signed [dhl_pkg::LENGTH_BITS-1:0] off_i,
  output dhl_pkg::result_t                       res_o
);

  localparam int TW = dhl_pkg::TW;
  localparam int TF = dhl_pkg::TRIG_FRAC_BITS;
  localparam int LB = dhl_pkg::LENGTH_BITS;
  localparam int PW = 2 * TW;
  localparam int MW = LB + TF + 1;
  localparam logic signed [PW-1:0] PRND   = PW'(1) <<< (TF - 1);
  localparam logic        [MW-1:0] MRND   = MW'(1) << (TF - 1);
  localparam logic        [LB:0]   MAXPOS = (LB + 1)'((64'(1) << (LB - 1)) - 64'(1));

  // First stage: products
  logic signed [PW-1:0] p01_q, p02_q, p11_q, p12_q;
  logic        [MW-1:0] mx_q, my_q;
  logic                 nx_q, ny_q;
  logic signed [TW-1:0] ct_q, st_q, ca_q, sa_q;
  logic signed [LB-1:0] off_q;

  logic [LB-1:0] ma;
  logic [TF:0]   mct, mst;

  always_comb begin
    ma  = len_i[LB-1] ? LB'(-len_i) : LB'(len_i);
    mct = ct_i[TW-1] ? (TF+1)'(-ct_i) : (TF+1)'(ct_i);
    mst = st_i[TW-1] ? (TF+1)'(-st_i) : (TF+1)'(st_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p01_q <= PW'(st_i) * PW'(ca_i);
      p02_q <= PW'(st_i) * PW'(sa_i);
      p11_q <= PW'(ct_i) * PW'(ca_i);
      p12_q <= PW'(ct_i) * PW'(sa_i);
      mx_q  <= MW'(ma) * MW'(mct);
      my_q  <= MW'(ma) * MW'(mst);
      nx_q  <= len_i[LB-1] ^ ct_i[TW-1];
      ny_q  <= len_i[LB-1] ^ st_i[TW-1];
      ct_q  <= ct_i;
      st_q  <= st_i;
      ca_q  <= ca_i;
      sa_q  <= sa_i;
      off_q <= off_i;
    end
  end

  // Second stage: round, negate, saturate
  logic signed [PW-1:0] r01, r02, r11, r12;
  logic        [MW-1:0] sx, sy;
  logic        [LB:0]   magx, magy;
  dhl_pkg::result_t     res_d, res_q;

  always_comb begin
    r01 = (p01_q + PRND) >>> TF;
    r02 = (p02_q + PRND) >>> TF;
    r11 = (p11_q + PRND) >>> TF;
    r12 = (p12_q + PRND) >>> TF;
    sx  = (mx_q + MRND) >> TF;
    sy  = (my_q + MRND) >> TF;
    magx = sx[LB:0];
    magy = sy[LB:0];
    res_d.rot_00 = ct_q;
    res_d.rot_01 = TW'(-r01);
    res_d.rot_02 = TW'(r02);
    res_d.rot_10 = st_q;
    res_d.rot_11 = TW'(r11);
    res_d.rot_12 = TW'(-r12);
    res_d.rot_21 = sa_q;
    res_d.rot_22 = ca_q;
    if (nx_q)               res_d.trans_x = LB'(-magx);
    else if (magx > MAXPOS) res_d.trans_x = LB'(MAXPOS);
    else                    res_d.trans_x = LB'(magx);
    if (ny_q)               res_d.trans_y = LB'(-magy);
    else if (magy > MAXPOS) res_d.trans_y = LB'(MAXPOS);
    else                    res_d.trans_y = LB'(magy);
    res_d.trans_z = off_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[design/dh_link_transform_unit.sv]
// Denavit-Hartenberg link transform. Each input transfer carries one link's offset d,
// joint angle theta, length a and twist alpha; each output transfer carries the eight
// non-constant rotation entries (signed Q1.14) and the translation (a*cos theta,
// a*sin theta, d) in signed Q16.16, saturated. Angles are binary, 65536 per turn, and
// every pattern is legal. Two 32-iteration CORDIC pipelines form the sines and cosines,
// one register per iteration, followed by a round/unfold stage, a multiply stage and a
// round/saturate stage; one transfer is accepted every cycle while the pipeline is not held.
// The whole pipeline holds when the output register is full and not taken, so
// s_axis_tready equals (!m_axis_tvalid || m_axis_tready).
module dh_link_transform_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // link_offset, joint_angle, link_length, link_twist (lowest bits first)
  input  logic [dhl_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_21, rot_22,
  // trans_x, trans_y, trans_z (lowest bits first), zero padded
  output logic [dhl_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int LB = dhl_pkg::LENGTH_BITS;
  localparam int AB = dhl_pkg::ANGLE_BITS;
  localparam int NS = dhl_pkg::NSTAGE;
  localparam int CL = dhl_pkg::CORD_LAT;

  logic adv;
  logic [NS-1:0] vld_q;

  // Advance every stage unless the output holds an untaken result
  assign adv           = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // Unpack the input fields
  logic signed [LB-1:0] offset, length;
  logic        [AB-1:0] theta, alpha;

  assign offset = s_axis_tdata[LB-1:0];
  assign theta  = s_axis_tdata[LB+AB-1:LB];
  assign length = s_axis_tdata[2*LB+AB-1:LB+AB];
  assign alpha  = s_axis_tdata[2*LB+2*AB-1:2*LB+AB];

  // Carry a and d alongside the CORDIC stages
  logic signed [LB-1:0] len_q [CL];
  logic signed [LB-1:0] off_q [CL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q[0] <= length;
      off_q[0] <= offset;
      for (int i = 1; i < CL; i++) begin
        len_q[i] <= len_q[i-1];
        off_q[i] <= off_q[i-1];
      end
    end
  end

  logic signed [dhl_pkg::TW-1:0] ct, st, ca, sa;

  dhl_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (theta),
    .cos_o   (ct),
    .sin_o   (st)
  );

  dhl_cordic u_cordic_alpha (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (alpha),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  dhl_pkg::result_t res;

  dhl_mult u_mult (
    .clk_i (clk_i),
    .adv_i (adv),
    .ct_i  (ct),
    .st_i  (st),
    .ca_i  (ca),
    .sa_i  (sa),
    .len_i (len_q[CL-1]),
    .off_i (off_q[CL-1]),
    .res_o (res)
  );

  assign m_axis_tdata = dhl_pkg::OUT_W'(res);

endmodule

[design/dhl_checker.sv]
module dhl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [dhl_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int TW = dhl_pkg::TW;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< dhl_pkg::TRIG_FRAC_BITS;

  logic signed [TW-1:0] r00, r22;
  assign r00 = m_axis_tdata[TW-1:0];
  assign r22 = m_axis_tdata[8*TW-1:7*TW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer dropped or changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> r00 <= ONE && r00 >= -ONE && r22 <= ONE && r22 >= -ONE)
    else $error("cosine entry out of range");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind dh_link_transform_unit dhl_checker u_dhl_checker (.*);
